FILE: rtl/core/b64_pkg.sv
// Base64 codec package: result bundle type, status and mode codes,
// alphabet and sextet lookup functions. No dependencies.
`timescale 1ns / 1ps

package b64_pkg;

    localparam logic       MODE_ENC = 1'b0;
    localparam logic       MODE_DEC = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_LEN = 2'd1;
    localparam logic [1:0] ST_PAD = 2'd2;
    localparam logic [1:0] ST_INV = 2'd3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] CODE_PAD = 8'h40;
    localparam logic [7:0] CODE_BAD = 8'hFF;

    // Results caused by one input word, drained one word per cycle while the output is ready.
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] data;
        logic            last;
        logic [1:0]      status;
    } res_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
                b64_char = w + 8'h41;
            else if (v < 6'd52)
                b64_char = w + 8'd71;
            else if (v < 6'd62)
                b64_char = w - 8'd4;
            else if (v == 6'd62)
                b64_char = 8'h2B;
            else
                b64_char = 8'h2F;
        end
    endfunction

    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        begin
            if (c >= 8'h41 && c <= 8'h5A)
                sextet_of = c - 8'h41;
            else if (c >= 8'h61 && c <= 8'h7A)
                sextet_of = c - 8'd71;
            else if (c >= 8'h30 && c <= 8'h39)
                sextet_of = c + 8'd4;
            else if (c == 8'h2B)
                sextet_of = 8'd62;
            else if (c == 8'h2F)
                sextet_of = 8'd63;
            else if (c == PAD_CHAR)
                sextet_of = CODE_PAD;
            else
                sextet_of = CODE_BAD;
        end
    endfunction

endpackage

FILE: rtl/core/b64_group.sv
// Base64 group engine: gathers bytes or sextets of one group, checks
// padding and characters, and forms the result bundle. Uses b64_pkg.
`timescale 1ns / 1ps

module b64_group
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clr,
    input  logic          mode,
    input  logic          step,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output b64_pkg::res_t res
);
    import b64_pkg::*;

    logic [23:0] bits_reg, bits_next;
    logic [1:0]  gc_reg, gc_next;
    logic [1:0]  pc_reg, pc_next;
    logic        skip_reg, skip_next;

    logic [23:0] enc_bits;
    logic [23:0] aligned;
    logic [2:0]  pos;
    logic [7:0]  s;
    logic [5:0]  s6;
    logic [1:0]  pc_new;
    logic [23:0] dec_bits;
    logic        fail;
    logic [1:0]  fail_st;

    always_comb
    begin
        bits_next = bits_reg;
        gc_next   = gc_reg;
        pc_next   = pc_reg;
        skip_next = skip_reg;
        res       = '0;
        fail      = 1'b0;
        fail_st   = ST_OK;
        pos       = {1'b0, gc_reg} + 3'd1;
        enc_bits  = {bits_reg[15:0], in_byte};
        aligned   = enc_bits;
        s         = sextet_of(in_byte);
        s6        = s[5:0];
        pc_new    = pc_reg;

        case (pos)
            3'd1:    aligned = {enc_bits[7:0], 16'h0000};
            3'd2:    aligned = {enc_bits[15:0], 8'h00};
            default: aligned = enc_bits;
        endcase

        if (s == CODE_PAD)
        begin
            s6 = 6'd0;
            if (pos == 3'd2)
                pc_new = 2'd3;
            else if (pos == 3'd3)
            begin
                if (pc_reg != 2'd3)
                    pc_new = 2'd1;
            end
            else if (pos == 3'd4)
            begin
                if (pc_reg != 2'd3)
                    pc_new = pc_reg + 2'd1;
            end
        end
        else if (pc_reg == 2'd1)
            pc_new = 2'd3;
        dec_bits = {bits_reg[17:0], s6};

        if (skip_reg)
        begin
            if (in_last)
            begin
                skip_next = 1'b0;
                bits_next = '0;
                gc_next   = '0;
                pc_next   = '0;
            end
        end
        else if (mode == MODE_ENC)
        begin
            if (pos < 3'd3 && !in_last)
            begin
                bits_next = enc_bits;
                gc_next   = pos[1:0];
            end
            else
            begin
                res.cnt     = 3'd4;
                res.last    = in_last;
                res.status  = ST_OK;
                res.data[0] = b64_char(aligned[23:18]);
                res.data[1] = b64_char(aligned[17:12]);
                res.data[2] = (pos < 3'd2) ? PAD_CHAR : b64_char(aligned[11:6]);
                res.data[3] = (pos < 3'd3) ? PAD_CHAR : b64_char(aligned[5:0]);
                bits_next   = '0;
                gc_next     = '0;
                pc_next     = '0;
            end
        end
        else
        begin
            if (in_last && pos < 3'd4)
            begin
                fail    = 1'b1;
                fail_st = ST_LEN;
            end
            else if (s == CODE_BAD)
            begin
                fail    = 1'b1;
                fail_st = ST_INV;
            end
            else if (s == CODE_PAD && pos == 3'd1)
            begin
                fail    = 1'b1;
                fail_st = ST_INV;
            end
            else if (pos < 3'd4)
            begin
                bits_next = dec_bits;
                gc_next   = pos[1:0];
                pc_next   = pc_new;
            end
            else if (!in_last)
            begin
                if (pc_new != 2'd0)
                begin
                    fail    = 1'b1;
                    fail_st = ST_INV;
                end
                else
                begin
                    res.cnt     = 3'd3;
                    res.last    = 1'b0;
                    res.data[0] = dec_bits[23:16];
                    res.data[1] = dec_bits[15:8];
                    res.data[2] = dec_bits[7:0];
                    bits_next   = '0;
                    gc_next     = '0;
                    pc_next     = '0;
                end
            end
            else if (pc_new == 2'd3)
            begin
                fail    = 1'b1;
                fail_st = ST_PAD;
            end
            else
            begin
                res.cnt     = 3'd3 - {1'b0, pc_new};
                res.last    = 1'b1;
                res.data[0] = dec_bits[23:16];
                res.data[1] = dec_bits[15:8];
                res.data[2] = dec_bits[7:0];
                bits_next   = '0;
                gc_next     = '0;
                pc_next     = '0;
            end

            if (fail)
            begin
                res         = '0;
                res.cnt     = 3'd1;
                res.last    = 1'b1;
                res.status  = fail_st;
                bits_next   = '0;
                gc_next     = '0;
                pc_next     = '0;
                skip_next   = !in_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            gc_reg   <= '0;
            pc_reg   <= '0;
            skip_reg <= 1'b0;
        end
        else if (clr)
        begin
            bits_reg <= '0;
            gc_reg   <= '0;
            pc_reg   <= '0;
            skip_reg <= 1'b0;
        end
        else if (step)
        begin
            bits_reg <= bits_next;
            gc_reg   <= gc_next;
            pc_reg   <= pc_next;
            skip_reg <= skip_next;
        end
    end

endmodule

FILE: rtl/core/b64_serializer.sv
// Base64 result serializer: holds one result bundle and sends its words
// one per cycle on the output stream while m_tready is high. Uses b64_pkg.
`timescale 1ns / 1ps

module b64_serializer
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  b64_pkg::res_t res,
    output logic          free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // [7:0] out_byte
    output logic          m_tlast,
    output logic [1:0]    m_tuser    // [1:0] status
);
    import b64_pkg::*;

    res_t       bun_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       final_word;

    assign final_word = ({1'b0, idx_reg} == bun_reg.cnt - 3'd1);
    assign free       = !busy_reg || (m_tready && final_word);

    assign m_tvalid = busy_reg;
    assign m_tdata  = bun_reg.data[idx_reg];
    assign m_tlast  = bun_reg.last && final_word;
    assign m_tuser  = bun_reg.status;

    always_ff @(posedge clk)
    begin
        if (load)
            bun_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && m_tready)
        begin
            if (final_word)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

FILE: rtl/core/base64_codec.sv
// Base64 codec top level: input register, mode register, group engine and
// result serializer. Depends on b64_pkg, b64_group and b64_serializer.
//
//   channel | signals                        | word
//   --------+--------------------------------+------------------------------
//   input   | s_tvalid s_tready s_tdata      | tdata[7:0] in_byte,
//           | s_tlast                        | tlast in_last
//   output  | m_tvalid m_tready m_tdata      | tdata[7:0] out_byte,
//           | m_tlast m_tuser                | tlast out_last, tuser status
//   config  | cfg_valid cfg_ready cfg_data   | cfg_data[0] mode
//
// A word is registered, then processed combinationally into a bundle of up to
// four result words. The serializer sends one result word per cycle while
// m_tready is high, so the single output port sets the pace. The input
// register can take the next word while a bundle is still being sent, and
// words that give no result pass without loading the serializer.
// Reset clears mode (encode), group state and the skip flag.
// An output stall holds the bundle; the input register then fills and
// s_tready drops.
`timescale 1ns / 1ps

module base64_codec
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser,   // [1:0] status
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_data   // [0] mode
);
    import b64_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       mode_reg;
    logic       cfg_wr;
    logic       fire;
    logic       ser_free;
    res_t       res;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign fire      = in_valid_reg && ((res.cnt == 3'd0) || ser_free);
    assign s_tready  = !in_valid_reg || fire;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_ENC;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (cfg_wr)
                mode_reg <= cfg_data[0];
        end
    end

    b64_group u_group
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (cfg_wr),
        .mode    (mode_reg),
        .step    (fire),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .res     (res)
    );

    b64_serializer u_ser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && (res.cnt != 3'd0)),
        .res      (res),
        .free     (ser_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for base64_codec: encode and decode messages with
// random idling on both stream sides. Depends on b64_pkg and base64_codec.
`timescale 1ns / 1ps

module tb;

    import b64_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int PAD_NONE      = 0;
    localparam int PAD_MISPLACED = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } out_word_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;
    logic [1:0] m_tuser;   // [1:0] status
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_data;  // [0] mode

    base64_codec dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Codec state as seen from outside
    logic        codec_mode;
    logic [23:0] grp_bits;
    int          grp_cnt;
    int          pad_st;
    logic        skipping;

    out_word_t   codec_out_due[$];
    logic [7:0]  msg_buf[$];

    int  mismatches;
    int  words_sent;
    int  enc_words;
    int  dec_words;
    int  results_seen;
    int  error_results;
    int  mode_writes;
    int  idle_cycles;
    bit  valid_up;
    bit  steady_flow;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s", msg);
    endtask

    function automatic logic [7:0] enc_letter(input int idx);
        if (idx < 26)
            return 8'("A" + idx);
        else if (idx < 52)
            return 8'("a" + idx - 26);
        else if (idx < 62)
            return 8'("0" + idx - 52);
        else if (idx == 62)
            return "+";
        else if (idx == 63)
            return "/";
        return PAD_CHAR;
    endfunction

    function automatic logic [7:0] code_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c - "A";
        if (c >= "a" && c <= "z")
            return c - "a" + 8'd26;
        if (c >= "0" && c <= "9")
            return c - "0" + 8'd52;
        if (c == "+")
            return 8'd62;
        if (c == "/")
            return 8'd63;
        if (c == PAD_CHAR)
            return CODE_PAD;
        return CODE_BAD;
    endfunction

    task automatic clear_group();
        grp_bits = '0;
        grp_cnt  = 0;
        pad_st   = PAD_NONE;
    endtask

    task automatic push_word(input logic [7:0] d, input logic l, input logic [1:0] st);
        out_word_t w;
        w.data   = d;
        w.last   = l;
        w.status = st;
        codec_out_due.push_back(w);
    endtask

    task automatic fail_word(input logic [1:0] st, input logic l);
        push_word(8'h00, 1'b1, st);
        clear_group();
        skipping = !l;
    endtask

    task automatic encode_step(input logic [7:0] b, input logic l);
        int          n;
        logic [23:0] bits;
        grp_bits = {grp_bits[15:0], b};
        n = grp_cnt + 1;
        if (n < 3 && !l)
        begin
            grp_cnt = n;
            return;
        end
        bits = grp_bits << ((3 - n) * 8);
        for (int k = 0; k < 4; k++)
        begin
            if (k > n)
                push_word(PAD_CHAR, l && k == 3, ST_OK);
            else
                push_word(enc_letter(int'((bits >> (18 - 6 * k)) & 24'h3F)),
                          l && k == 3, ST_OK);
        end
        clear_group();
    endtask

    task automatic decode_step(input logic [7:0] c, input logic l);
        logic [7:0] s;
        int         pos;
        int         n;
        s   = code_of(c);
        pos = grp_cnt + 1;
        if (l && pos < 4)
        begin
            fail_word(ST_LEN, l);
            return;
        end
        if (s == CODE_BAD)
        begin
            fail_word(ST_INV, l);
            return;
        end
        if (s == CODE_PAD)
        begin
            if (pos == 1)
            begin
                fail_word(ST_INV, l);
                return;
            end
            if (pos == 2)
                pad_st = PAD_MISPLACED;
            else if (pos == 3)
            begin
                if (pad_st != PAD_MISPLACED)
                    pad_st = 1;
            end
            else if (pad_st != PAD_MISPLACED)
                pad_st++;
            s = 8'h00;
        end
        else if (pad_st == 1)
            pad_st = PAD_MISPLACED;
        grp_bits = {grp_bits[17:0], s[5:0]};
        if (pos < 4)
        begin
            grp_cnt = pos;
            return;
        end
        if (!l)
        begin
            if (pad_st != PAD_NONE)
            begin
                fail_word(ST_INV, l);
                return;
            end
            for (int k = 0; k < 3; k++)
                push_word(8'(grp_bits >> (16 - 8 * k)), 1'b0, ST_OK);
            clear_group();
            return;
        end
        if (pad_st == PAD_MISPLACED)
        begin
            fail_word(ST_PAD, l);
            return;
        end
        n = 3 - pad_st;
        for (int k = 0; k < n; k++)
            push_word(8'(grp_bits >> (16 - 8 * k)), k == n - 1, ST_OK);
        clear_group();
    endtask

    task automatic codec_step(input logic [7:0] b, input logic l);
        if (skipping)
        begin
            if (l)
            begin
                skipping = 1'b0;
                clear_group();
            end
            return;
        end
        if (codec_mode == MODE_ENC)
            encode_step(b, l);
        else
            decode_step(b, l);
    endtask

    // Drop s_tvalid before any wait so an accepted word is not sent again
    task automatic drop_input_valid();
        if (valid_up)
        begin
            s_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            drop_input_valid();
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        valid_up = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        if (codec_mode == MODE_ENC)
            enc_words++;
        else
            dec_words++;
        codec_step(b, l);
    endtask

    task automatic send_msg_buf();
        for (int i = 0; i < msg_buf.size(); i++)
            send_word(msg_buf[i], i == msg_buf.size() - 1);
        msg_buf.delete();
    endtask

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++)
            msg_buf.push_back(t[i]);
    endtask

    task automatic wait_drained();
        drop_input_valid();
        do
            @(posedge clk);
        while (codec_out_due.size() != 0);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        codec_mode = m;
        clear_group();
        skipping = 1'b0;
        mode_writes++;
    endtask

    task automatic test_encode_directed();
        write_mode(MODE_ENC);
        msg_buf = '{8'h00, 8'hFF, 8'h80};
        send_msg_buf();
        msg_buf = '{8'hFF};
        send_msg_buf();
        msg_buf = '{8'h01, 8'hFE};
        send_msg_buf();
    endtask

    task automatic test_decode_directed();
        write_mode(MODE_DEC);
        // full groups, then two pads over non-zero bits
        add_text("AZaz09+/TR==");
        send_msg_buf();
        // short message wins over a bad character
        add_text("A");
        msg_buf.push_back(CODE_BAD);
        send_msg_buf();
        // pad as first character
        add_text("=A");
        send_msg_buf();
        // NUL mid-stream, rest skipped
        add_text("Q");
        msg_buf.push_back(8'h00);
        add_text("x");
        send_msg_buf();
        // lone pad in third place of the final group
        add_text("AB=C");
        send_msg_buf();
        // misplaced pad in a group that is not final
        add_text("A=AAB");
        send_msg_buf();
        // proper padding, but the group is not final
        add_text("AB==A");
        send_msg_buf();
    endtask

    task automatic test_random_encode(input int n_words);
        int start;
        int len;
        start = words_sent;
        write_mode(MODE_ENC);
        while (words_sent - start < n_words)
        begin
            steady_flow = ($urandom_range(0, 3) == 0);
            len = $urandom_range(1, 10);
            repeat (len) msg_buf.push_back(8'($urandom_range(0, 255)));
            send_msg_buf();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        steady_flow = 1'b0;
    endtask

    task automatic build_b64_text();
        int groups;
        int pads;
        int at;
        groups = $urandom_range(1, 3);
        repeat (groups * 4) msg_buf.push_back(enc_letter($urandom_range(0, 63)));
        pads = $urandom_range(0, 3);
        if (pads >= 1 && pads <= 2)
        begin
            msg_buf[msg_buf.size() - 1] = PAD_CHAR;
            if (pads == 2)
                msg_buf[msg_buf.size() - 2] = PAD_CHAR;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            at = $urandom_range(0, msg_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: msg_buf[at] = 8'($urandom_range(0, 255));
                1: msg_buf[at] = PAD_CHAR;
                2: repeat ($urandom_range(1, 3))
                    if (msg_buf.size() > 1)
                        void'(msg_buf.pop_back());
                default: msg_buf.push_back(enc_letter($urandom_range(0, 63)));
            endcase
        end
    endtask

    task automatic test_random_decode(input int n_words);
        int start;
        start = words_sent;
        write_mode(MODE_DEC);
        while (words_sent - start < n_words)
        begin
            steady_flow = ($urandom_range(0, 3) == 0);
            build_b64_text();
            send_msg_buf();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        steady_flow = 1'b0;
    endtask

    // Result side: random stalls, compare each word with the oldest prediction
    initial
    begin
        out_word_t want;
        int        stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_seen++;
            if (m_tuser != ST_OK)
                error_results++;
            if (codec_out_due.size() == 0)
                report_mismatch($sformatf("word %02h last %0d status %0d with none pending",
                                          m_tdata, m_tlast, m_tuser));
            else
            begin
                want = codec_out_due.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("result %0d data %02h, predicted %02h",
                                              results_seen, m_tdata, want.data));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("result %0d last %0d, predicted %0d",
                                              results_seen, m_tlast, want.last));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                              results_seen, m_tuser, want.status));
            end
        end
    end

    // The limit is far above the longest legal quiet stretch
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles, %0d results pending",
                     STALL_LIMIT, codec_out_due.size());
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        codec_mode  = MODE_ENC;
        skipping    = 1'b0;
        valid_up    = 1'b0;
        steady_flow = 1'b0;
        clear_group();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_directed();
        test_decode_directed();
        test_random_encode(70);
        test_random_decode(90);
        test_random_encode(40);
        test_random_decode(50);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d input words (%0d encode, %0d decode) over %0d mode writes",
                 words_sent, enc_words, dec_words, mode_writes);
        $display("checked %0d result words, %0d of them error status, %0d mismatches",
                 results_seen, error_results, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
